/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
	localparam int DEPTH = 16;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [VAL_W-1:0] entry;
		logic [CNT_W-1:0] count;
		logic last;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;
endpackage
`default_nettype wire

/* hdl/spq_cell.sv */
// One storage cell of the sorted chain with its compare and shift logic.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
	input wire logic clk,
	input wire spq_pkg::cell_cmd_t cmd,
	input wire logic occupied,
	input wire logic left_hit,
	input wire logic signed [spq_pkg::VAL_W-1:0] left_value,
	input wire logic signed [spq_pkg::VAL_W-1:0] right_value,
	input wire logic right_occupied,
	input wire logic signed [spq_pkg::VAL_W-1:0] head_value,
	output logic signed [spq_pkg::VAL_W-1:0] value,
	output logic hit,
	output logic eq
);
	import spq_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic ge;

	assign ge = occupied && (cmd.value >= value_q);
	assign hit = !occupied || ge;
	assign eq = occupied && (cmd.value == value_q);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (left_hit) begin
					value_q <= left_value;
				end else if (hit) begin
					value_q <= cmd.value;
				end
			end
			CELL_DELETE: begin
				if (ge) begin
					value_q <= right_value;
				end
			end
			CELL_ROTATE: begin
				if (occupied) begin
					value_q <= right_occupied ? right_value : head_value;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

/* hdl/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
`timescale 1ns / 1ps
`default_nettype none
// Insert, delete and unused codes need no busy state: the result strobes on done in the
// cycle after the transfer and busy stays low, so a new command may follow every cycle.
// A read-out raises busy while its stored entries are emitted, one entry per cycle,
// highest first, as the cell chain rotates past its head; the chain is back in order when
// busy falls. An empty read-out gives one result and busy stays low. Results cannot be held
// off and must be taken in the cycle done is high.
module sorted_priority_queue_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire spq_pkg::req_t req,
	output logic busy,
	output logic done,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] rd_cnt_q;
	logic done_q;
	rsp_t rsp_q;

	logic signed [VAL_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0] cell_hit;
	logic [DEPTH-1:0] cell_eq;
	logic [DEPTH-1:0] cell_occ;
	logic found;
	logic accept;
	logic full;
	logic empty;
	cell_cmd_t cmd;

	assign accept = start && (state_q == S_IDLE);
	assign full = (occ_q == OCC_W'(DEPTH));
	assign empty = (occ_q == '0);
	assign found = |cell_eq;

	always_comb begin
		cmd.value = req.value;
		cmd.op = CELL_HOLD;
		if (state_q == S_READ) begin
			cmd.op = CELL_ROTATE;
		end else if (accept) begin
			if (req.func == FUNC_INSERT && !full) begin
				cmd.op = CELL_INSERT;
			end else if (req.func == FUNC_DELETE && !empty && found) begin
				cmd.op = CELL_DELETE;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_occ[i] = OCC_W'(i) < occ_q;
		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk(clk),
				.cmd(cmd),
				.occupied(cell_occ[i]),
				.left_hit(1'b0),
				.left_value(cell_value[i]),
				.right_value(cell_value[i+1]),
				.right_occupied(cell_occ[i+1]),
				.head_value(cell_value[0]),
				.value(cell_value[i]),
				.hit(cell_hit[i]),
				.eq(cell_eq[i])
			);
		end else if (i == DEPTH - 1) begin : g_tail
			spq_cell u_cell (
				.clk(clk),
				.cmd(cmd),
				.occupied(cell_occ[i]),
				.left_hit(cell_hit[i-1]),
				.left_value(cell_value[i-1]),
				.right_value(cell_value[i]),
				.right_occupied(1'b0),
				.head_value(cell_value[0]),
				.value(cell_value[i]),
				.hit(cell_hit[i]),
				.eq(cell_eq[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk(clk),
				.cmd(cmd),
				.occupied(cell_occ[i]),
				.left_hit(cell_hit[i-1]),
				.left_value(cell_value[i-1]),
				.right_value(cell_value[i+1]),
				.right_occupied(cell_occ[i+1]),
				.head_value(cell_value[0]),
				.value(cell_value[i]),
				.hit(cell_hit[i]),
				.eq(cell_eq[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			rd_cnt_q <= '0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_q.entry <= '0;
						rsp_q.last <= 1'b1;
						rsp_q.count <= CNT_W'(occ_q);
						rsp_q.status <= STATUS_OK;
						case (req.func)
							FUNC_INSERT: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q.status <= STATUS_FULL;
								end else begin
									occ_q <= occ_q + 1'b1;
									rsp_q.count <= CNT_W'(occ_q + 1'b1);
								end
							end
							FUNC_DELETE: begin
								done_q <= 1'b1;
								if (empty) begin
									rsp_q.status <= STATUS_EMPTY;
								end else if (!found) begin
									rsp_q.status <= STATUS_NOT_FOUND;
								end else begin
									occ_q <= occ_q - 1'b1;
									rsp_q.count <= CNT_W'(occ_q - 1'b1);
								end
							end
							FUNC_READ: begin
								if (empty) begin
									done_q <= 1'b1;
									rsp_q.status <= STATUS_EMPTY;
								end else begin
									rd_cnt_q <= occ_q;
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					done_q <= 1'b1;
					rsp_q.status <= STATUS_OK;
					rsp_q.entry <= cell_value[0];
					rsp_q.count <= CNT_W'(occ_q);
					rsp_q.last <= (rd_cnt_q == OCC_W'(1));
					rd_cnt_q <= rd_cnt_q - 1'b1;
					if (rd_cnt_q == OCC_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_READ);
	assign done = done_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire
